// ===== design/jlaw_pkg.sv =====
`timescale 1ns / 1ps

package jlaw_pkg;

    localparam int JLAW_FRAC_BITS = 16;
    localparam int JLAW_W = 165;
    localparam int JLAW_QB = 33;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] limit_low;
        logic signed [31:0] limit_high;
        logic               joint_present;
        logic               last_joint;
    } jlaw_in_t;

    typedef struct packed {
        logic [31:0] weight;
        logic        penalized;
        logic        saturated;
        logic        last_weight;
    } jlaw_out_t;

    typedef struct packed {
        logic                valid;
        logic                active;
        logic                zero;
        logic                big;
        logic                last;
        logic [JLAW_W-1:0]   rem;
        logic [JLAW_W-1:0]   den;
        logic [JLAW_QB-1:0]  quo;
    } jlaw_div_t;

endpackage

// ===== design/jlaw_div_stage.sv =====
`timescale 1ns / 1ps

module jlaw_div_stage #(
    parameter int SHIFT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  jlaw_pkg::jlaw_div_t d,
    output jlaw_pkg::jlaw_div_t q
);
    import jlaw_pkg::*;

    jlaw_div_t          stage_reg;
    jlaw_div_t          stage_next;
    logic [JLAW_W:0]    diff;

    always_comb
    begin
        diff = {1'b0, d.rem} - {1'b0, d.den << SHIFT};
        stage_next = d;
        if (d.active && !d.zero && !d.big && !diff[JLAW_W])
        begin
            stage_next.rem = diff[JLAW_W-1:0];
            stage_next.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign q = stage_reg;

endmodule

// ===== design/joint_limit_avoidance_weight.sv =====
`timescale 1ns / 1ps
// An accepted request passes through s1 to s4, s5, the division chain and the output register.
// Throughput: one joint per cycle; the whole pipeline halts while a result is stalled.
// The penalty quotient is formed by 33 registered restoring-division steps.
// Reset (rst_n, asynchronous, active low) clears every stage's valid bit.

module joint_limit_avoidance_weight #(
    parameter int FRAC_BITS = jlaw_pkg::JLAW_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                joint_valid,
    output logic                joint_stall,
    input  jlaw_pkg::jlaw_in_t  joint,
    output logic                result_valid,
    input  logic                result_stall,
    output jlaw_pkg::jlaw_out_t result
);
    import jlaw_pkg::*;

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
    localparam logic [JLAW_QB-1:0] CAP = {1'b0, 32'hFFFFFFFF} - {1'b0, ONE};

    logic adv;

    logic signed [32:0] dmax;
    logic signed [32:0] dmin;
    logic signed [32:0] span;
    logic signed [34:0] mid;
    logic [32:0]        span_abs;
    logic [33:0]        mid_abs;
    logic [32:0]        dmax_abs;
    logic [32:0]        dmin_abs;
    logic               toward;

    logic        s1_valid_reg, s1_active_reg, s1_last_reg;
    logic [32:0] s1_a_reg, s1_c_reg, s1_d_reg;
    logic [33:0] s1_b_reg;

    logic        s2_valid_reg, s2_active_reg, s2_last_reg;
    logic [65:0] s2_a2_reg, s2_c2_reg, s2_d2_reg;
    logic [33:0] s2_b_reg;

    logic        s3_valid_reg, s3_active_reg, s3_last_reg;
    logic [67:0] s3_nh_reg;
    logic [65:0] s3_nl_reg;
    logic [67:0] s3_hh_reg;
    logic [65:0] s3_hl_reg, s3_lh_reg;
    logic [63:0] s3_ll_reg;

    logic              s4_valid_reg, s4_active_reg, s4_last_reg;
    logic [JLAW_W-1:0] s4_x_reg, s4_d_reg;
    logic [JLAW_W-1:0] n_sum, d_sum;

    jlaw_div_t s5_reg;
    jlaw_div_t s5_next;
    jlaw_div_t div_chain [0:JLAW_QB];

    jlaw_out_t out_reg;
    jlaw_out_t out_next;
    logic      out_valid_reg;
    jlaw_div_t fin;
    logic      pen;
    logic      sat;

    assign adv = !out_valid_reg || !result_stall;
    assign joint_stall = !adv;

    always_comb
    begin
        dmax = {joint.limit_high[31], joint.limit_high} - {joint.position[31], joint.position};
        dmin = {joint.position[31], joint.position} - {joint.limit_low[31], joint.limit_low};
        span = {joint.limit_high[31], joint.limit_high} - {joint.limit_low[31], joint.limit_low};
        mid  = {{2{joint.position[31]}}, joint.position, 1'b0}
             - {{3{joint.limit_high[31]}}, joint.limit_high}
             - {{3{joint.limit_low[31]}}, joint.limit_low};
        span_abs = span[32] ? 33'(-span) : 33'(span);
        mid_abs  = mid[34] ? 34'(-mid) : 34'(mid);
        dmax_abs = dmax[32] ? 33'(-dmax) : 33'(dmax);
        dmin_abs = dmin[32] ? 33'(-dmin) : 33'(dmin);
        toward = (!joint.velocity[31] && (joint.velocity != 32'sd0) && (dmax < dmin))
              || (joint.velocity[31] && (dmax > dmin));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= joint_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_active_reg <= joint.joint_present && toward;
            s1_last_reg   <= joint.last_joint;
            s1_a_reg      <= span_abs;
            s1_b_reg      <= mid_abs;
            s1_c_reg      <= dmax_abs;
            s1_d_reg      <= dmin_abs;

            s2_active_reg <= s1_active_reg;
            s2_last_reg   <= s1_last_reg;
            s2_a2_reg     <= s1_a_reg * s1_a_reg;
            s2_c2_reg     <= s1_c_reg * s1_c_reg;
            s2_d2_reg     <= s1_d_reg * s1_d_reg;
            s2_b_reg      <= s1_b_reg;

            s3_active_reg <= s2_active_reg;
            s3_last_reg   <= s2_last_reg;
            s3_nh_reg     <= s2_a2_reg[65:32] * s2_b_reg;
            s3_nl_reg     <= s2_a2_reg[31:0] * s2_b_reg;
            s3_hh_reg     <= s2_c2_reg[65:32] * s2_d2_reg[65:32];
            s3_hl_reg     <= s2_c2_reg[65:32] * s2_d2_reg[31:0];
            s3_lh_reg     <= s2_c2_reg[31:0] * s2_d2_reg[65:32];
            s3_ll_reg     <= s2_c2_reg[31:0] * s2_d2_reg[31:0];

            s4_active_reg <= s3_active_reg;
            s4_last_reg   <= s3_last_reg;
            s4_x_reg      <= n_sum << (2 * FRAC_BITS);
            s4_d_reg      <= d_sum << 2;
        end
    end

    always_comb
    begin
        n_sum = (JLAW_W'(s3_nh_reg) << 32) + JLAW_W'(s3_nl_reg);
        d_sum = (JLAW_W'(s3_hh_reg) << 64)
              + ((JLAW_W'(s3_hl_reg) + JLAW_W'(s3_lh_reg)) << 32)
              + JLAW_W'(s3_ll_reg);
    end

    always_comb
    begin
        s5_next.valid  = s4_valid_reg;
        s5_next.active = s4_active_reg;
        s5_next.last   = s4_last_reg;
        s5_next.zero   = (s4_d_reg == '0);
        s5_next.big    = (s4_x_reg >= (s4_d_reg << JLAW_QB));
        s5_next.rem    = s4_x_reg;
        s5_next.den    = s4_d_reg;
        s5_next.quo    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s5_reg <= s5_next;
        end
    end

    assign div_chain[0] = s5_reg;

    for (genvar k = 0; k < JLAW_QB; k++)
    begin : g_div
        jlaw_div_stage #(
            .SHIFT(JLAW_QB - 1 - k)
        ) u_stage (
            .clk  (clk),
            .rst_n(rst_n),
            .adv  (adv),
            .d    (div_chain[k]),
            .q    (div_chain[k+1])
        );
    end

    always_comb
    begin
        fin = div_chain[JLAW_QB];
        pen = fin.active && !fin.zero;
        sat = pen && (fin.big || (fin.quo > CAP));
        out_next.penalized   = pen;
        out_next.saturated   = sat;
        out_next.last_weight = fin.last;
        if (!pen)
        begin
            out_next.weight = ONE;
        end
        else if (sat)
        begin
            out_next.weight = 32'hFFFFFFFF;
        end
        else
        begin
            out_next.weight = ONE + fin.quo[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

`ifndef SYNTHESIS
    a_sat_needs_pen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |-> result.penalized)
        else $error("Saturated weight without the penalty term.");
    a_plain_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.penalized |-> result.weight == ONE)
        else $error("Unpenalised weight differs from one.");
    a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |-> result.weight == 32'hFFFFFFFF)
        else $error("Saturated weight is not the format maximum.");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> joint_stall)
        else $error("Pipeline advanced while a result was stalled.");
`endif

endmodule
